### src/index_word_quality_filter_core_assert.svh
// Assertion macros shared by the filter modules.
// Each macro expects clk and rst_n in scope.
`ifndef INDEX_WORD_QUALITY_FILTER_CORE_ASSERT_SVH
`define INDEX_WORD_QUALITY_FILTER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define IWQF_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("iwqf check failed");

// Next-cycle implication.
`define IWQF_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("iwqf check failed");

`else

`define IWQF_ASSERT_IMP(lbl, ant, con)
`define IWQF_ASSERT_NXT(lbl, ant, con)

`endif

`endif

### src/iwqf_pkg.sv
package iwqf_pkg;

  // Width of the length and run counters.
  localparam int COUNT_WIDTH = 8;
  // Width of a configured limit.
  localparam int LIMIT_WIDTH = 8;
  // Width used when a counter is compared against a limit.
  localparam int CMP_WIDTH = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;
  localparam int CHAR_WIDTH = 8;
  localparam int MODE_WIDTH = 3;
  localparam int CFG_IDX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = 8;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [LIMIT_WIDTH-1:0] limit_t;
  typedef logic [CHAR_WIDTH-1:0] char_t;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_MIN_LENGTH        = 3'd0,
    REG_MAX_LENGTH        = 3'd1,
    REG_MAX_SAME_REPEAT   = 3'd2,
    REG_MAX_DIGIT_RUN     = 3'd3,
    REG_MAX_VOWEL_RUN     = 3'd4,
    REG_MAX_CONSONANT_RUN = 3'd5,
    REG_REJECT_MODES      = 3'd6
  } cfg_reg_t;

  // Bit positions inside reject_modes.
  localparam int MODE_ALL_VOWEL     = 0;
  localparam int MODE_ALL_CONSONANT = 1;
  localparam int MODE_ALL_DIGIT     = 2;

  // Current configuration, as seen by the word logic.
  typedef struct packed {
    limit_t                min_length;
    limit_t                max_length;
    limit_t                max_same_repeat;
    limit_t                max_digit_run;
    limit_t                max_vowel_run;
    limit_t                max_consonant_run;
    logic [MODE_WIDTH-1:0] reject_modes;
  } cfg_t;

  // Control from the input stage to the word logic.
  typedef struct packed {
    logic step;
    logic last;
  } word_ctl_t;

endpackage

### src/index_word_quality_filter_core.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+--------------------------------
// input    | in_valid / in_ready  | in_char_code[7:0], in_last
// result   | out_valid / out_ready| out_word_ok
// config   | cfg_we               | cfg_index[2:0], cfg_wdata[7:0]
//
// One character per cycle sustained unless a held result stalls a last character;
// the last character of a word passes the input register, then its verdict the result register.
// Word state updates in one pass between the input and result registers.
// Reset (rst_n low, synchronous) clears word state and loads defaults.
// A held result stalls only a last character; other characters keep flowing.
`include "index_word_quality_filter_core_assert.svh"

module index_word_quality_filter_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [iwqf_pkg::CHAR_WIDTH-1:0]     in_char_code,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_word_ok,
  input  logic                                cfg_we,
  input  logic [iwqf_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [iwqf_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata
);
  import iwqf_pkg::*;

  cfg_t      cfg;
  word_ctl_t ctl;
  logic      in_valid_r;
  char_t     in_char_r;
  logic      in_last_r;
  logic      out_valid_r;
  logic      out_word_ok_r;
  logic      word_ok;
  logic      step;

  iwqf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Process the held item unless it is a last one and a full result slot is not being read.
  assign step     = in_valid_r && (!in_last_r || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step;
  assign ctl      = '{step: step, last: in_last_r};

  iwqf_word u_word (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .char_code (in_char_r),
    .cfg       (cfg),
    .word_ok   (word_ok)
  );

  // Input register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  // Capture the item payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_char_r <= in_char_code;
      in_last_r <= in_last;
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Capture the verdict.
  always_ff @(posedge clk) begin
    if (step && in_last_r) begin
      out_word_ok_r <= word_ok;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_word_ok = out_word_ok_r;

  `IWQF_ASSERT_IMP(a_mid_word_never_stalls, in_valid_r && !in_last_r, step)
  `IWQF_ASSERT_NXT(a_last_gives_result, step && in_last_r, out_valid_r)
  `IWQF_ASSERT_NXT(a_blocked_last_holds, in_valid_r && in_last_r && out_valid_r && !out_ready,
                   in_valid_r && in_last_r)

endmodule

### src/iwqf_cfg_regs.sv
module iwqf_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [iwqf_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
  input  logic [iwqf_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata,
  output iwqf_pkg::cfg_t                      cfg
);
  import iwqf_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write into the addressed register.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_LENGTH:        cfg_nxt.min_length        = cfg_wdata[LIMIT_WIDTH-1:0];
        REG_MAX_LENGTH:        cfg_nxt.max_length        = cfg_wdata[LIMIT_WIDTH-1:0];
        REG_MAX_SAME_REPEAT:   cfg_nxt.max_same_repeat   = cfg_wdata[LIMIT_WIDTH-1:0];
        REG_MAX_DIGIT_RUN:     cfg_nxt.max_digit_run     = cfg_wdata[LIMIT_WIDTH-1:0];
        REG_MAX_VOWEL_RUN:     cfg_nxt.max_vowel_run     = cfg_wdata[LIMIT_WIDTH-1:0];
        REG_MAX_CONSONANT_RUN: cfg_nxt.max_consonant_run = cfg_wdata[LIMIT_WIDTH-1:0];
        REG_REJECT_MODES:      cfg_nxt.reject_modes      = cfg_wdata[MODE_WIDTH-1:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  // Hold the registers, loading defaults at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_length        <= LIMIT_WIDTH'(1);
      cfg_r.max_length        <= LIMIT_WIDTH'(40);
      cfg_r.max_same_repeat   <= LIMIT_WIDTH'(100);
      cfg_r.max_digit_run     <= LIMIT_WIDTH'(4);
      cfg_r.max_vowel_run     <= LIMIT_WIDTH'(10);
      cfg_r.max_consonant_run <= LIMIT_WIDTH'(60);
      cfg_r.reject_modes      <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### src/iwqf_word.sv
`include "index_word_quality_filter_core_assert.svh"

module iwqf_word (
  input  logic                  clk,
  input  logic                  rst_n,
  input  iwqf_pkg::word_ctl_t   ctl,
  input  iwqf_pkg::char_t       char_code,
  input  iwqf_pkg::cfg_t        cfg,
  output logic                  word_ok
);
  import iwqf_pkg::*;

  typedef enum logic [1:0] {
    CLS_DIGIT,
    CLS_VOWEL,
    CLS_CONSONANT,
    CLS_PUNCT
  } char_class_t;

  localparam cnt_t COUNT_MAX = '1;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic over_limit(input cnt_t v, input limit_t lim);
    return CMP_WIDTH'(v) > CMP_WIDTH'(lim);
  endfunction

  function automatic char_class_t classify(input char_t c);
    char_t low;
    char_class_t cls;
    low = c | 8'h20;
    if (c >= 8'h30 && c <= 8'h39) begin
      cls = CLS_DIGIT;
    end else if (c >= 8'h41 && c <= 8'h7A &&
                 (low == 8'h61 || low == 8'h65 || low == 8'h69 ||
                  low == 8'h6F || low == 8'h75)) begin
      cls = CLS_VOWEL;
    end else if ((c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
                 (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E)) begin
      cls = CLS_PUNCT;
    end else begin
      cls = CLS_CONSONANT;
    end
    return cls;
  endfunction

  char_t       prev_char_r;
  cnt_t        same_cnt_r,  same_cnt_nxt;
  cnt_t        digit_cnt_r, digit_cnt_nxt;
  cnt_t        vowel_cnt_r, vowel_cnt_nxt;
  cnt_t        cons_cnt_r,  cons_cnt_nxt;
  cnt_t        length_r,    length_nxt;
  logic        seen_digit_r, seen_digit_nxt;
  logic        seen_vowel_r, seen_vowel_nxt;
  logic        seen_cons_r,  seen_cons_nxt;
  logic        rejected_r,   rejected_nxt;
  char_class_t cls;
  logic        len_bad;

  // Update the word state with one character and form the verdict.
  always_comb begin
    cls            = classify(char_code);
    length_nxt     = sat_inc(length_r);
    same_cnt_nxt   = '0;
    digit_cnt_nxt  = digit_cnt_r;
    vowel_cnt_nxt  = vowel_cnt_r;
    cons_cnt_nxt   = cons_cnt_r;
    seen_digit_nxt = seen_digit_r;
    seen_vowel_nxt = seen_vowel_r;
    seen_cons_nxt  = seen_cons_r;
    rejected_nxt   = rejected_r;

    if (char_code == prev_char_r) begin
      same_cnt_nxt = sat_inc(same_cnt_r);
      if (over_limit(same_cnt_nxt, cfg.max_same_repeat)) rejected_nxt = 1'b1;
    end

    // Punctuation leaves the digit, vowel and consonant runs untouched.
    case (cls)
      CLS_DIGIT: begin
        seen_digit_nxt = 1'b1;
        digit_cnt_nxt  = sat_inc(digit_cnt_r);
        vowel_cnt_nxt  = '0;
        cons_cnt_nxt   = '0;
        if (over_limit(digit_cnt_nxt, cfg.max_digit_run)) rejected_nxt = 1'b1;
      end
      CLS_VOWEL: begin
        seen_vowel_nxt = 1'b1;
        vowel_cnt_nxt  = sat_inc(vowel_cnt_r);
        digit_cnt_nxt  = '0;
        cons_cnt_nxt   = '0;
        if (over_limit(vowel_cnt_nxt, cfg.max_vowel_run)) rejected_nxt = 1'b1;
      end
      CLS_CONSONANT: begin
        seen_cons_nxt = 1'b1;
        cons_cnt_nxt  = sat_inc(cons_cnt_r);
        digit_cnt_nxt = '0;
        vowel_cnt_nxt = '0;
        if (over_limit(cons_cnt_nxt, cfg.max_consonant_run)) rejected_nxt = 1'b1;
      end
      default: begin
      end
    endcase

    len_bad = (CMP_WIDTH'(length_nxt) < CMP_WIDTH'(cfg.min_length)) ||
              (CMP_WIDTH'(length_nxt) > CMP_WIDTH'(cfg.max_length));

    word_ok = !rejected_nxt && !len_bad &&
      !(cfg.reject_modes[MODE_ALL_VOWEL] && seen_vowel_nxt && !seen_cons_nxt) &&
      !(cfg.reject_modes[MODE_ALL_CONSONANT] && seen_cons_nxt && !seen_vowel_nxt) &&
      !(cfg.reject_modes[MODE_ALL_DIGIT] && seen_digit_nxt && !seen_vowel_nxt &&
        !seen_cons_nxt);
  end

  // Advance the state per item; clear it after the last character.
  always_ff @(posedge clk) begin
    if (!rst_n || (ctl.step && ctl.last)) begin
      prev_char_r  <= '0;
      same_cnt_r   <= '0;
      digit_cnt_r  <= '0;
      vowel_cnt_r  <= '0;
      cons_cnt_r   <= '0;
      length_r     <= '0;
      seen_digit_r <= 1'b0;
      seen_vowel_r <= 1'b0;
      seen_cons_r  <= 1'b0;
      rejected_r   <= 1'b0;
    end else if (ctl.step) begin
      prev_char_r  <= char_code;
      same_cnt_r   <= same_cnt_nxt;
      digit_cnt_r  <= digit_cnt_nxt;
      vowel_cnt_r  <= vowel_cnt_nxt;
      cons_cnt_r   <= cons_cnt_nxt;
      length_r     <= length_nxt;
      seen_digit_r <= seen_digit_nxt;
      seen_vowel_r <= seen_vowel_nxt;
      seen_cons_r  <= seen_cons_nxt;
      rejected_r   <= rejected_nxt;
    end
  end

  `IWQF_ASSERT_NXT(a_clear_after_last, ctl.step && ctl.last, length_r == '0)
  `IWQF_ASSERT_IMP(a_same_within_len, 1'b1, same_cnt_r <= length_r)
  `IWQF_ASSERT_IMP(a_digit_within_len, 1'b1, digit_cnt_r <= length_r)

endmodule

### tb/index_word_quality_filter_core_tb.sv
module index_word_quality_filter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iwqf_pkg::*;

  typedef enum {CH_DIGIT, CH_VOWEL, CH_CONSONANT, CH_PUNCT} char_class_t;

  typedef enum {
    ST_MIXED, ST_VOWELS, ST_CONSONANTS, ST_DIGITS,
    ST_DIGIT_PUNCT, ST_PUNCT, ST_ANY_BYTE, ST_RUN
  } word_style_t;

  // Tracks the word state and the settings, and queues one verdict per finished word
  class verdict_tracker;
    cfg_t  limits;
    char_t prev_char;
    cnt_t  same_run;
    cnt_t  digit_run;
    cnt_t  vowel_run;
    cnt_t  consonant_run;
    cnt_t  word_len;
    bit    has_digit;
    bit    has_vowel;
    bit    has_consonant;
    bit    failed;
    bit    pending_verdicts[$];
    int    mismatch_count;

    function new();
      limits.min_length        = limit_t'(1);
      limits.max_length        = limit_t'(40);
      limits.max_same_repeat   = limit_t'(100);
      limits.max_digit_run     = limit_t'(4);
      limits.max_vowel_run     = limit_t'(10);
      limits.max_consonant_run = limit_t'(60);
      limits.reject_modes      = '0;
      mismatch_count           = 0;
      clear_word();
    endfunction

    function void clear_word();
      prev_char     = '0;
      same_run      = '0;
      digit_run     = '0;
      vowel_run     = '0;
      consonant_run = '0;
      word_len      = '0;
      has_digit     = 1'b0;
      has_vowel     = 1'b0;
      has_consonant = 1'b0;
      failed        = 1'b0;
    endfunction

    // Saturate at the counter maximum
    function cnt_t bump(cnt_t v);
      return (v == '1) ? v : cnt_t'(v + 1'b1);
    endfunction

    function char_class_t char_class(char_t c);
      char_t folded;
      folded = c | 8'h20;
      if (c >= "0" && c <= "9")
        return CH_DIGIT;
      if (c >= 8'h41 && c <= 8'h7A &&
          (folded == "a" || folded == "e" || folded == "i" ||
           folded == "o" || folded == "u"))
        return CH_VOWEL;
      if ((c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
          (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E))
        return CH_PUNCT;
      return CH_CONSONANT;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_WIDTH-1:0] v);
      case (idx)
        REG_MIN_LENGTH:        limits.min_length = v;
        REG_MAX_LENGTH:        limits.max_length = v;
        REG_MAX_SAME_REPEAT:   limits.max_same_repeat = v;
        REG_MAX_DIGIT_RUN:     limits.max_digit_run = v;
        REG_MAX_VOWEL_RUN:     limits.max_vowel_run = v;
        REG_MAX_CONSONANT_RUN: limits.max_consonant_run = v;
        REG_REJECT_MODES:      limits.reject_modes = v[MODE_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    // Advance the word state by one accepted character
    function void take_char(char_t c, bit is_last);
      bit ok;
      word_len = bump(word_len);
      if (c == prev_char) begin
        same_run = bump(same_run);
        if (same_run > limits.max_same_repeat) failed = 1'b1;
      end else begin
        same_run = '0;
      end

      case (char_class(c))
        CH_DIGIT: begin
          has_digit = 1'b1;
          digit_run = bump(digit_run);
          if (digit_run > limits.max_digit_run) failed = 1'b1;
          vowel_run     = '0;
          consonant_run = '0;
        end
        CH_VOWEL: begin
          has_vowel = 1'b1;
          vowel_run = bump(vowel_run);
          if (vowel_run > limits.max_vowel_run) failed = 1'b1;
          digit_run     = '0;
          consonant_run = '0;
        end
        CH_CONSONANT: begin
          has_consonant = 1'b1;
          consonant_run = bump(consonant_run);
          if (consonant_run > limits.max_consonant_run) failed = 1'b1;
          digit_run = '0;
          vowel_run = '0;
        end
        default: ;  // punctuation holds the digit, vowel and consonant runs
      endcase
      prev_char = c;

      if (!is_last) return;

      ok = !failed;
      if (word_len < limits.min_length || word_len > limits.max_length) ok = 1'b0;
      if (limits.reject_modes[MODE_ALL_VOWEL] && has_vowel && !has_consonant) ok = 1'b0;
      if (limits.reject_modes[MODE_ALL_CONSONANT] && has_consonant && !has_vowel) ok = 1'b0;
      if (limits.reject_modes[MODE_ALL_DIGIT] && has_digit && !has_vowel && !has_consonant)
        ok = 1'b0;
      pending_verdicts.push_back(ok);
      clear_word();
    endfunction

    // Compare a delivered verdict with the oldest one queued
    function void match_verdict(logic got);
      bit want;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: word_ok expected none, actual %b", $time, got);
        mismatch_count++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (got !== want) begin
        $display("%0t: word_ok expected %b, actual %b", $time, want, got);
        mismatch_count++;
      end
    endfunction
  endclass

  logic     clk;
  logic     rst_n        = 1'b0;
  logic     in_valid     = 1'b0;
  logic     in_ready;
  char_t    in_char_code = '0;
  logic     in_last      = 1'b0;
  logic     out_valid;
  logic     out_ready    = 1'b0;
  logic     out_word_ok;
  logic     cfg_we       = 1'b0;
  cfg_reg_t cfg_index    = REG_MIN_LENGTH;
  logic [CFG_DATA_WIDTH-1:0] cfg_wdata = '0;

  verdict_tracker tracker = new();
  int unsigned    chars_sent = 0;
  bit             in_calm = 1'b0;

  index_word_quality_filter_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_word_ok  (out_word_ok),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Draw a character of the given class
  function automatic char_t pick_char(char_class_t k);
    string vowels = "aeiouAEIOU";
    string letters = "bcdfghjklmnpqrstvwxyzBCDFGHJKLMNPQRSTVWXYZ";
    int unsigned r;
    case (k)
      CH_DIGIT: return char_t'(8'h30 + $urandom_range(0, 9));
      CH_VOWEL: return vowels[$urandom_range(0, 9)];
      CH_CONSONANT: begin
        if ($urandom_range(0, 3) != 0) return letters[$urandom_range(0, 41)];
        // control bytes, space and the upper half
        r = $urandom_range(0, 160);
        return (r < 32) ? char_t'(r + 1) : char_t'(r - 32 + 8'h7F);
      end
      default: begin
        r = $urandom_range(0, 31);
        if (r < 15) return char_t'(8'h21 + r);
        if (r < 22) return char_t'(8'h3A + r - 15);
        if (r < 28) return char_t'(8'h5B + r - 22);
        return char_t'(8'h7B + r - 28);
      end
    endcase
  endfunction

  function automatic cfg_t make_settings(int unsigned mn, int unsigned mx, int unsigned rep,
                                         int unsigned dg, int unsigned vw, int unsigned cs,
                                         int unsigned md);
    cfg_t s;
    s.min_length        = limit_t'(mn);
    s.max_length        = limit_t'(mx);
    s.max_same_repeat   = limit_t'(rep);
    s.max_digit_run     = limit_t'(dg);
    s.max_vowel_run     = limit_t'(vw);
    s.max_consonant_run = limit_t'(cs);
    s.reject_modes      = md[MODE_WIDTH-1:0];
    return s;
  endfunction

  // Offer one character after a random gap and hold it until accepted
  task automatic send_char(char_t c, bit is_last);
    int unsigned gap;
    gap = in_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    in_last      <= is_last;
    do @(posedge clk); while (in_ready !== 1'b1);
    tracker.take_char(c, is_last);
    chars_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_word(int len, word_style_t st);
    char_t       c;
    char_t       prev;
    char_t       run_char;
    char_class_t k;
    in_calm  = ($urandom_range(0, 3) == 0);
    run_char = pick_char(char_class_t'($urandom_range(0, 3)));
    prev     = run_char;
    for (int i = 0; i < len; i++) begin
      case (st)
        ST_MIXED:       k = char_class_t'($urandom_range(0, 3));
        ST_VOWELS:      k = ($urandom_range(0, 5) == 0) ? CH_PUNCT : CH_VOWEL;
        ST_CONSONANTS:  k = ($urandom_range(0, 5) == 0) ? CH_PUNCT : CH_CONSONANT;
        ST_DIGITS:      k = CH_DIGIT;
        ST_DIGIT_PUNCT: k = ($urandom_range(0, 2) == 0) ? CH_PUNCT : CH_DIGIT;
        default:        k = CH_PUNCT;
      endcase
      if (st == ST_RUN)
        c = run_char;
      else if (st == ST_ANY_BYTE)
        c = char_t'($urandom_range(1, 255));
      else if (i > 0 && $urandom_range(0, 3) == 0)
        c = prev;
      else
        c = pick_char(k);
      send_char(c, i == len - 1);
      prev = c;
    end
  endtask

  task automatic run_phase(int unsigned budget);
    int unsigned start;
    int          len;
    start = chars_sent;
    while (chars_sent - start < budget) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
      send_word(len, word_style_t'($urandom_range(0, 7)));
    end
  endtask

  // Drop valid and wait until every queued verdict is out and the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_WIDTH-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    tracker.set_reg(idx, v);
  endtask

  task automatic apply_settings(cfg_t s);
    write_reg(REG_MIN_LENGTH, s.min_length);
    write_reg(REG_MAX_LENGTH, s.max_length);
    write_reg(REG_MAX_SAME_REPEAT, s.max_same_repeat);
    write_reg(REG_MAX_DIGIT_RUN, s.max_digit_run);
    write_reg(REG_MAX_VOWEL_RUN, s.max_vowel_run);
    write_reg(REG_MAX_CONSONANT_RUN, s.max_consonant_run);
    write_reg(REG_REJECT_MODES, CFG_DATA_WIDTH'(s.reject_modes));
    cfg_we <= 1'b0;
  endtask

  // Result side: stall a random number of cycles per verdict, with calm stretches
  initial begin
    int unsigned stall;
    int unsigned calm_left;
    calm_left = 0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (calm_left > 0) begin
        calm_left--;
        stall = 0;
      end else begin
        stall = $urandom_range(0, 4);
        if ($urandom_range(0, 7) == 0) calm_left = $urandom_range(5, 25);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      tracker.match_verdict(out_word_ok);
    end
  end

  initial begin
    cfg_t s;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under reset settings: classes, byte extremes, repeats, punctuation
    send_text("a");
    send_text("12345");
    send_text("Ab9!");
    send_text("aaa");
    send_char(8'h01, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h7F, 1'b0);
    send_char(8'h80, 1'b1);
    send_text("~@");
    run_phase(70);

    for (int p = 1; p < 10; p++) begin
      settle();
      case (p)
        1: s = make_settings(1, 254, 0, 0, 0, 0, 7);          // zero limits, all modes
        2: s = make_settings(254, 1, 254, 254, 254, 254, 0);  // length bounds crossed
        3: s = make_settings(1, 254, 254, 254, 254, 254, 0);
        4: s = make_settings(2, 8, 1, 2, 2, 3, 1);
        5: s = make_settings(1, 12, 2, 3, 3, 4, 2);
        6: s = make_settings(1, 20, 3, 6, 4, 5, 4);
        default: s = make_settings($urandom_range(1, 6), $urandom_range(1, 24),
                                   $urandom_range(0, 5), $urandom_range(0, 6),
                                   $urandom_range(0, 6), $urandom_range(0, 8),
                                   $urandom_range(0, 7));
      endcase
      apply_settings(s);
      if (p == 3) begin
        // longest accepted length, then one repeated character to pin its counters
        send_word(254, ST_MIXED);
        send_word(258, ST_RUN);
      end
      run_phase(70);
    end

    // Drain the remaining verdicts
    in_valid <= 1'b0;
    while (tracker.pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Hard stop for a hung handshake
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
